@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Concurrent assertion on a clock, active during reset too.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ rtl/rpd_pkg.sv @@
// Package with types and constants of the packet deframer.
`timescale 1ns / 1ps

package rpd_pkg;

    localparam logic [7:0] CH_START          = 8'h24;
    localparam logic [7:0] CH_END            = 8'h23;
    localparam logic [7:0] CH_ESC            = 8'h7D;
    localparam logic [7:0] ESC_XOR           = 8'h20;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd190;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PAYLOAD   = 2'd0,
        CFG_CHECKSUM_MODE = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BADSUM  = 3'd2,
        KIND_BADHEX  = 3'd3,
        KIND_OVER    = 3'd4
    } t_kind;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_BODY    = 8'b0000_0010,
        PH_ESCAPED = 8'b0000_0100,
        PH_SUM_HI  = 8'b0000_1000,
        PH_SUM_LO  = 8'b0001_0000,
        PH_DRAIN   = 8'b0010_0000,
        PH_SKIP_HI = 8'b0100_0000,
        PH_SKIP_LO = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] payload_length;
        logic       last;
    } t_result;

endpackage

@@ rtl/rpd_ifs.sv @@
// Channel interfaces: received bytes, results and register writes.
`timescale 1ns / 1ps

interface rpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rpd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] payload_length;
    logic       last;
    modport source (output valid, output kind, output data_byte,
                    output payload_length, output last, input ready);
    modport sink (input valid, input kind, input data_byte,
                  input payload_length, input last, output ready);
endinterface

interface rpd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rpd_pkg::CFG_IDX_W-1:0] reg_index;
    logic [rpd_pkg::CFG_DATA_W-1:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/rpd_in_stage.sv @@
// Input register for received bytes.
`timescale 1ns / 1ps

module rpd_in_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpd_byte_if.sink    i_byte,
    input  logic        i_out_free,
    output logic        o_fire,
    output logic [7:0]  o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    assign o_fire       = r_valid && i_out_free;
    assign i_byte.ready = !r_valid || o_fire;
    assign o_byte       = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.rx_byte;
        end
    end
endmodule

@@ rtl/rpd_core.sv @@
// Framing state machine, checksum and result decode.
`timescale 1ns / 1ps

module rpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_max_payload,
    input  logic             i_checksum_mode,
    output logic             o_res_valid,
    output rpd_pkg::t_result o_res
);
    import rpd_pkg::*;

    t_phase     r_phase,    n_phase;
    logic [7:0] r_checksum, n_checksum;
    logic [7:0] r_count,    n_count;
    logic [3:0] r_hi,       n_hi;
    logic       r_hi_bad,   n_hi_bad;

    logic [7:0] absorbed;
    logic [4:0] hex_dec;
    logic [7:0] sum_rx;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        priority if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end else begin
            return 5'd0;
        end
    endfunction

    assign absorbed = i_checksum_mode ? (r_checksum + i_byte) : (r_checksum ^ i_byte);
    assign hex_dec  = hex_decode(i_byte);
    assign sum_rx   = {r_hi, hex_dec[3:0]};

    always_comb begin
        n_phase     = r_phase;
        n_checksum  = r_checksum;
        n_count     = r_count;
        n_hi        = r_hi;
        n_hi_bad    = r_hi_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == CH_START) begin
                        n_phase    = PH_BODY;
                        n_checksum = 8'd0;
                        n_count    = 8'd0;
                        n_hi       = 4'd0;
                        n_hi_bad   = 1'b0;
                    end
                end
                PH_BODY: begin
                    if (i_byte == CH_END) begin
                        n_phase = PH_SUM_HI;
                    end else if (r_count >= i_max_payload) begin
                        n_phase = PH_DRAIN;
                    end else begin
                        n_checksum = absorbed;
                        if (i_byte == CH_ESC) begin
                            n_phase = PH_ESCAPED;
                        end else begin
                            n_count           = r_count + 8'd1;
                            o_res_valid       = 1'b1;
                            o_res.kind        = KIND_DATA;
                            o_res.data_byte   = i_byte;
                        end
                    end
                end
                PH_ESCAPED: begin
                    n_checksum      = absorbed;
                    n_count         = r_count + 8'd1;
                    n_phase         = PH_BODY;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_DATA;
                    o_res.data_byte = i_byte ^ ESC_XOR;
                end
                PH_SUM_HI: begin
                    n_hi     = hex_dec[3:0];
                    n_hi_bad = !hex_dec[4];
                    n_phase  = PH_SUM_LO;
                end
                PH_SUM_LO: begin
                    n_phase              = PH_HUNT;
                    o_res_valid          = 1'b1;
                    o_res.payload_length = r_count;
                    o_res.last           = 1'b1;
                    priority if (!hex_dec[4] || r_hi_bad) begin
                        o_res.kind = KIND_BADHEX;
                    end else if (sum_rx != r_checksum) begin
                        o_res.kind = KIND_BADSUM;
                    end else begin
                        o_res.kind = KIND_GOOD;
                    end
                end
                PH_DRAIN: begin
                    if (i_byte == CH_END) begin
                        n_phase = PH_SKIP_HI;
                    end
                end
                PH_SKIP_HI: begin
                    n_phase = PH_SKIP_LO;
                end
                PH_SKIP_LO: begin
                    n_phase              = PH_HUNT;
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_OVER;
                    o_res.payload_length = r_count;
                    o_res.last           = 1'b1;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_checksum <= 8'd0;
            r_count    <= 8'd0;
            r_hi       <= 4'd0;
            r_hi_bad   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_checksum <= n_checksum;
            r_count    <= n_count;
            r_hi       <= n_hi;
            r_hi_bad   <= n_hi_bad;
        end
    end
endmodule

@@ rtl/rpd_out_stage.sv @@
// Result register toward the output channel.
`timescale 1ns / 1ps

module rpd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_res_valid,
    input  rpd_pkg::t_result i_res,
    output logic             o_free,
    rpd_result_if.source     o_res
);
    import rpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free               = !r_valid || o_res.ready;
    assign o_res.valid          = r_valid;
    assign o_res.kind           = r_res.kind;
    assign o_res.data_byte      = r_res.data_byte;
    assign o_res.payload_length = r_res.payload_length;
    assign o_res.last           = r_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= i_res_valid;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end
endmodule

@@ rtl/rsp_packet_deframer.sv @@
// Path: a byte goes from the input register through the combinational core into the result register.
// Throughput: one byte per cycle; the state update and the result register load at
// the same edge, and ready falls only while both stages are full and the result waits.
// Reset: synchronous active-low; clears both pipeline stages, the framing
// state (hunting for start) and the registers (max_payload 190, XOR mode).
`timescale 1ns / 1ps

module rsp_packet_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpd_byte_if.sink      i_byte,
    rpd_cfg_if.sink       i_cfg,
    rpd_result_if.source  o_res
);
    import rpd_pkg::*;

    logic [7:0] r_max_payload_q;
    logic       r_checksum_mode;

    logic       fire;
    logic [7:0] stage_byte;
    logic       out_free;
    logic       res_valid;
    t_result    res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload_q <= MAX_PAYLOAD_RESET;
            r_checksum_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.reg_index))
                CFG_MAX_PAYLOAD:   r_max_payload_q <= i_cfg.wr_data;
                CFG_CHECKSUM_MODE: r_checksum_mode <= i_cfg.wr_data[0];
                default: begin
                end
            endcase
        end
    end

    rpd_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_byte     (stage_byte)
    );

    rpd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_byte          (stage_byte),
        .i_max_payload   (r_max_payload_q),
        .i_checksum_mode (r_checksum_mode),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    rpd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_res       (o_res)
    );
endmodule

@@ rtl/rpd_checker.sv @@
// Port checker for the packet deframer and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [2:0] i_kind,
    input logic [7:0] i_data_byte,
    input logic [7:0] i_payload_length,
    input logic       i_last
);
    import rpd_pkg::*;

    `ASSERT_CLK_RST(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_kind) && $stable(i_data_byte) && $stable(i_payload_length))
    `ASSERT_CLK_RST(a_last_on_end, i_clk, i_rst_n, i_res_valid |-> (i_last == (i_kind != KIND_DATA)))
    `ASSERT_CLK_RST(a_data_fields, i_clk, i_rst_n, i_res_valid && i_kind == KIND_DATA |-> i_payload_length == 8'd0)
    `ASSERT_CLK_RST(a_end_fields, i_clk, i_rst_n, i_res_valid && i_kind != KIND_DATA |-> i_data_byte == 8'd0 && (i_kind == KIND_GOOD || i_kind == KIND_BADSUM || i_kind == KIND_BADHEX || i_kind == KIND_OVER))
    `ASSERT_CLK(a_reset_idle, i_clk, !i_rst_n |=> !i_res_valid)
endmodule

bind rsp_packet_deframer rpd_checker u_rpd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_kind           (o_res.kind),
    .i_data_byte      (o_res.data_byte),
    .i_payload_length (o_res.payload_length),
    .i_last           (o_res.last)
);
